@@ hw/rtl/dltq_pkg.sv @@
// dltq_pkg: shared constants and types for the delta list timer queue
// used by dltq_cell and delta_list_timer_queue_core
`default_nettype none
package dltq_pkg;
   localparam int TIMERS     = 16;
   localparam int DELAY_BITS = 32;
   localparam int NUM_IDS    = 16;
   localparam int CAPACITY   = (TIMERS < NUM_IDS) ? TIMERS : NUM_IDS;
   localparam int CNT_BITS   = $clog2(TIMERS + 1);

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_CANCEL = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   localparam logic [1:0] EV_ADDED     = 2'd0;
   localparam logic [1:0] EV_CANCELLED = 2'd1;
   localparam logic [1:0] EV_EXPIRED   = 2'd2;
   localparam logic [1:0] EV_REJECTED  = 2'd3;

   // per-cycle command broadcast to every cell
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT_UP,
      CMD_SHIFT_DOWN
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [CNT_BITS-1:0]    pos;
      logic [DELAY_BITS-1:0]  ins_delta;
      logic [3:0]             ins_id;
   } cell_ctl_type;
endpackage
`default_nettype wire

@@ hw/rtl/dltq_cell.sv @@
// dltq_cell: one entry of the delta list with its delta and id
// depends on dltq_pkg; neighbours feed shift data in both directions
`default_nettype none
module dltq_cell (
   input  wire logic                            clock,
   input  wire dltq_pkg::cell_ctl_type          ctl,
   input  wire logic [dltq_pkg::CNT_BITS-1:0]   my_pos,
   input  wire logic                            wr_delta,
   input  wire logic [dltq_pkg::DELAY_BITS-1:0] wr_value,
   input  wire logic [dltq_pkg::DELAY_BITS-1:0] below_delta,
   input  wire logic [3:0]                      below_id,
   input  wire logic [dltq_pkg::DELAY_BITS-1:0] above_delta,
   input  wire logic [3:0]                      above_id,
   output logic      [dltq_pkg::DELAY_BITS-1:0] delta,
   output logic      [3:0]                      id
);
   logic [dltq_pkg::DELAY_BITS-1:0] delta_ff, delta_in;
   logic [3:0]                      id_ff, id_in;

   // choose from the neighbour, the insert value, or hold
   always_comb begin
      delta_in = delta_ff;
      id_in    = id_ff;
      unique case (ctl.cmd)
         dltq_pkg::CMD_SHIFT_UP: begin
            if (my_pos > ctl.pos) begin
               delta_in = below_delta;
               id_in    = below_id;
            end else if (my_pos == ctl.pos) begin
               delta_in = ctl.ins_delta;
               id_in    = ctl.ins_id;
            end
         end
         dltq_pkg::CMD_SHIFT_DOWN: begin
            if (my_pos >= ctl.pos) begin
               delta_in = above_delta;
               id_in    = above_id;
            end
         end
         default: ;
      endcase
      // a direct delta write wins over the shifted delta
      if (wr_delta) begin
         delta_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      id_ff    <= id_in;
   end

   assign delta = delta_ff;
   assign id    = id_ff;
endmodule
`default_nettype wire

@@ hw/rtl/delta_list_timer_queue_core.sv @@
// delta_list_timer_queue_core: delta list timer queue top level
// depends on dltq_pkg and dltq_cell; a sequencer walks the cell row
// add: the sequencer walks the row to find the place, then loads the result; cancel: the same walk
// tick: decrements the head delta, then pops each expired entry; no result if none expires
// one transaction in flight; the next waits until the result register has drained
// reset (synchronous) empties the list; cell contents stay undefined
`default_nettype none
module delta_list_timer_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_timer_id,
   input  wire logic [31:0] req_delay,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [1:0]  rsp_event_res,
   output logic      [3:0]  rsp_timer_id_res,
   output logic             rsp_last
);
   localparam int DB = dltq_pkg::DELAY_BITS;
   localparam int CB = dltq_pkg::CNT_BITS;
   localparam int T  = dltq_pkg::TIMERS;
   localparam int PB = (T > 1) ? $clog2(T) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD, ST_CANCEL, ST_TICK, ST_POP, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [CB-1:0]         count_ff;
   logic [15:0]           pending_ff;
   logic [CB-1:0]         walk_ff;
   logic [DB-1:0]         rem_ff;
   logic [3:0]            id_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            ev_ff;
   logic [3:0]            rid_ff;
   logic                  last_ff;
   logic                  go_out_ff;

   logic [DB-1:0] cell_delta [T];
   logic [3:0]    cell_id [T];
   dltq_pkg::cell_ctl_type ctl;
   logic          wr_en;
   logic [PB-1:0] wr_idx;
   logic [DB-1:0] wr_val;

   logic [PB-1:0] widx;
   logic [DB-1:0] cur_delta;
   logic [3:0]    cur_id;
   logic [DB-1:0] req_delay_m;
   logic          out_free;
   logic          req_fire;
   logic          pop_now;
   logic          rsp_set;

   assign widx        = walk_ff[PB-1:0];
   assign cur_delta   = cell_delta[widx];
   assign cur_id      = cell_id[widx];
   assign req_delay_m = DB'(req_delay);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_fire    = req_valid && !req_stall;
   assign pop_now     = out_free && count_ff != '0 && cell_delta[0] == '0;
   assign rsp_set     = ((state_ff == ST_OUT) && out_free) || ((state_ff == ST_POP) && pop_now);

   // row of cells
   for (genvar g = 0; g < T; g++) begin : g_cell
      logic [DB-1:0] bd, ad;
      logic [3:0]    bi, ai;
      if (g == 0) begin : g_lo
         assign bd = '0;
         assign bi = '0;
      end else begin : g_mid
         assign bd = cell_delta[g-1];
         assign bi = cell_id[g-1];
      end
      if (g == T - 1) begin : g_hi
         assign ad = '0;
         assign ai = '0;
      end else begin : g_top
         assign ad = cell_delta[g+1];
         assign ai = cell_id[g+1];
      end
      dltq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .my_pos      (CB'(g)),
         .wr_delta    (wr_en && (wr_idx == PB'(g))),
         .wr_value    (wr_val),
         .below_delta (bd),
         .below_id    (bi),
         .above_delta (ad),
         .above_id    (ai),
         .delta       (cell_delta[g]),
         .id          (cell_id[g])
      );
   end

   // cell commands from the sequencer state
   always_comb begin
      ctl.cmd       = dltq_pkg::CMD_HOLD;
      ctl.pos       = walk_ff;
      ctl.ins_delta = rem_ff;
      ctl.ins_id    = id_ff;
      wr_en         = 1'b0;
      wr_idx        = widx;
      wr_val        = '0;
      unique case (state_ff)
         ST_ADD: begin
            if (walk_ff == count_ff) begin
               ctl.cmd = dltq_pkg::CMD_SHIFT_UP;
            end else if (rem_ff < cur_delta) begin
               // successor moves up one place and keeps what is left of its delta
               ctl.cmd = dltq_pkg::CMD_SHIFT_UP;
               wr_en   = 1'b1;
               wr_idx  = PB'(walk_ff + CB'(1));
               wr_val  = cur_delta - rem_ff;
            end
         end
         ST_CANCEL: begin
            if (walk_ff != count_ff && cur_id == id_ff) begin
               // successor moves down into this place and takes the removed delta
               ctl.cmd = dltq_pkg::CMD_SHIFT_DOWN;
               if (walk_ff + CB'(1) < count_ff) begin
                  wr_en  = 1'b1;
                  wr_val = cell_delta[PB'(walk_ff + CB'(1))] + cur_delta;
               end
            end
         end
         ST_TICK: begin
            wr_en  = (cell_delta[0] != '0);
            wr_idx = '0;
            wr_val = cell_delta[0] - DB'(1);
         end
         ST_POP: begin
            if (pop_now) begin
               ctl.cmd = dltq_pkg::CMD_SHIFT_DOWN;
               ctl.pos = '0;
            end
         end
         default: ;
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         go_out_ff    <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  id_ff   <= req_timer_id;
                  rem_ff  <= req_delay_m;
                  walk_ff <= '0;
                  rid_ff  <= req_timer_id;
                  last_ff <= 1'b1;
                  ev_ff   <= dltq_pkg::EV_REJECTED;
                  unique case (req_action)
                     dltq_pkg::ACT_ADD: begin
                        if (req_delay_m == '0 || pending_ff[req_timer_id]
                            || count_ff >= CB'(dltq_pkg::CAPACITY)) begin
                           state_ff <= ST_OUT;
                        end else begin
                           state_ff <= ST_ADD;
                        end
                     end
                     dltq_pkg::ACT_CANCEL: begin
                        state_ff <= pending_ff[req_timer_id] ? ST_CANCEL : ST_OUT;
                     end
                     dltq_pkg::ACT_TICK: begin
                        state_ff <= (count_ff == '0) ? ST_IDLE : ST_TICK;
                     end
                     default: state_ff <= ST_OUT;
                  endcase
               end
            end
            ST_ADD: begin
               if (walk_ff == count_ff || rem_ff < cur_delta) begin
                  count_ff           <= count_ff + CB'(1);
                  pending_ff[id_ff]  <= 1'b1;
                  ev_ff              <= dltq_pkg::EV_ADDED;
                  state_ff           <= ST_OUT;
               end else begin
                  rem_ff  <= rem_ff - cur_delta;
                  walk_ff <= walk_ff + CB'(1);
               end
            end
            ST_CANCEL: begin
               if (walk_ff == count_ff) begin
                  state_ff <= ST_OUT;
               end else if (cur_id == id_ff) begin
                  count_ff          <= count_ff - CB'(1);
                  pending_ff[id_ff] <= 1'b0;
                  ev_ff             <= dltq_pkg::EV_CANCELLED;
                  state_ff          <= ST_OUT;
               end else begin
                  walk_ff <= walk_ff + CB'(1);
               end
            end
            ST_TICK: begin
               state_ff <= ST_POP;
            end
            ST_POP: begin
               if (out_free) begin
                  if (pop_now) begin
                     ev_ff                  <= dltq_pkg::EV_EXPIRED;
                     rid_ff                 <= cell_id[0];
                     pending_ff[cell_id[0]] <= 1'b0;
                     count_ff               <= count_ff - CB'(1);
                     last_ff <= (count_ff == CB'(1)) || (T < 2) || (cell_delta[PB'(1 % T)] != '0);
                     if ((count_ff == CB'(1)) || (T < 2) || (cell_delta[PB'(1 % T)] != '0)) begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         go_out_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = ev_ff;
   assign rsp_timer_id_res = rid_ff;
   assign rsp_last         = last_ff;

   // checks on the sequencer
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(dltq_pkg::CAPACITY))
      else $error("entry count above capacity");
   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      $countones(pending_ff) == int'(count_ff))
      else $error("pending mask disagrees with entry count");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("accepting while busy");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_event_res) && !go_out_ff))
      else $error("stalled result changed");
endmodule
`default_nettype wire
